// ----- rtl/sabs_pkg.sv -----
// Package for the size-aware batch splitter: widths, constants, register
// indexes and the divide-by-five helper. No dependencies.
`timescale 1ns / 1ps

package sabs_pkg;

    // Field widths.
    localparam int LEN_W   = 24;
    localparam int CNT_W   = 16;
    localparam int ROW_W   = 25;
    localparam int BYTES_W = 31;
    localparam int MB_W    = 11;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;

    // Row estimate constants: base overhead, encryption overhead, MiB shift.
    localparam logic [ROW_W:0]   ROW_BASE  = (ROW_W + 1)'(909);
    localparam logic [LEN_W-1:0] ENC_EXTRA = LEN_W'(200);
    localparam int               MIB_SHIFT = 20;
    localparam logic [ROW_W-1:0] ROW_MAX   = '1;

    // floor(x/5) for x below 2^25: x*ceil(2^26/5) >> 26 is exact in that range.
    localparam logic [23:0] DIV5_MUL   = 24'd13421773;
    localparam int          DIV5_SHIFT = 26;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_SIZE_MODE  = 3'd0,
        CFG_ENCRYPT_ON = 3'd1,
        CFG_TARGET_MB  = 3'd2,
        CFG_MAX_MB     = 3'd3,
        CFG_MIN_MSGS   = 3'd4,
        CFG_MAX_MSGS   = 3'd5,
        CFG_CHUNK_MSGS = 3'd6
    } t_cfg_idx;

    // Divide a value below 2^25 by five with one multiply.
    function automatic logic [22:0] div5(input logic [24:0] x);
        logic [48:0] prod;
        prod = {24'b0, x} * {25'b0, DIV5_MUL};
        return prod[48:DIV5_SHIFT];
    endfunction

endpackage

// ----- rtl/size_aware_batch_splitter_unit.sv -----
// Top level of the size-aware batch splitter: row size pipeline, batch decision
// and result register. Depends on sabs_pkg.
`timescale 1ns / 1ps

// Stages: input register, encryption overhead, base size, row size, decision
// and result register. Throughput: one word per cycle while the result side
// does not stall; the running byte sum and count update in the single cycle
// that moves a word from the row stage into the result register.
// Reset (i_rst_n low at a clock edge) empties the pipeline, clears the byte sum
// and count, and loads the configuration registers with their defaults.
module size_aware_batch_splitter_unit
    import sabs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [LEN_W-1:0]   i_payload_len,
    input  logic               i_last_item,
    // Configuration write channel.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [DATA_W-1:0]  i_cfg_data,
    // Result channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_prev_closed,
    output logic [CNT_W-1:0]   o_prev_count,
    output logic [BYTES_W-1:0] o_prev_bytes,
    output logic               o_final_closed,
    output logic [CNT_W-1:0]   o_final_count,
    output logic [BYTES_W-1:0] o_final_bytes,
    output logic [ROW_W-1:0]   o_row_bytes
);

    // Configuration registers.
    logic             r_size_mode;
    logic             r_encrypt_on;
    logic [MB_W-1:0]  r_target_mb;
    logic [MB_W-1:0]  r_max_mb;
    logic [CNT_W-1:0] r_min_msgs;
    logic [CNT_W-1:0] r_max_msgs;
    logic [CNT_W-1:0] r_chunk_msgs;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_mode  <= 1'b1;
            r_encrypt_on <= 1'b0;
            r_target_mb  <= MB_W'(4);
            r_max_mb     <= MB_W'(8);
            r_min_msgs   <= CNT_W'(100);
            r_max_msgs   <= CNT_W'(10000);
            r_chunk_msgs <= CNT_W'(1000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SIZE_MODE:  r_size_mode  <= i_cfg_data[0];
                CFG_ENCRYPT_ON: r_encrypt_on <= i_cfg_data[0];
                CFG_TARGET_MB:  r_target_mb  <= i_cfg_data[MB_W-1:0];
                CFG_MAX_MB:     r_max_mb     <= i_cfg_data[MB_W-1:0];
                CFG_MIN_MSGS:   r_min_msgs   <= i_cfg_data[CNT_W-1:0];
                CFG_MAX_MSGS:   r_max_msgs   <= i_cfg_data[CNT_W-1:0];
                CFG_CHUNK_MSGS: r_chunk_msgs <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline occupancy and per-stage load enables.
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic rdy_out, rdy4, rdy3, rdy2, rdy1;

    assign rdy_out = !r_out_valid || !i_stall;
    assign rdy4    = !r_v4 || rdy_out;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1)    r_v1        <= i_valid;
            if (rdy2)    r_v2        <= r_v1;
            if (rdy3)    r_v3        <= r_v2;
            if (rdy4)    r_v4        <= r_v3;
            if (rdy_out) r_out_valid <= r_v4;
        end
    end

    // Stage 1: input register.
    logic [LEN_W-1:0] r_len1;
    logic             r_last1;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_len1  <= i_payload_len;
            r_last1 <= i_last_item;
        end
    end

    // Stage 2: encryption overhead, floor(len*7/20) + 200 when enabled.
    logic [LEN_W+2:0] len_x7;
    logic [22:0]      enc_q;
    logic [LEN_W-1:0] n_enc;
    logic [LEN_W-1:0] r_len2;
    logic [LEN_W-1:0] r_enc2;
    logic             r_last2;

    assign len_x7 = {r_len1, 3'b0} - {3'b0, r_len1};
    assign enc_q  = div5(len_x7[LEN_W+2:2]);
    assign n_enc  = r_encrypt_on ? (LEN_W'(enc_q) + ENC_EXTRA) : '0;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_len2  <= r_len1;
            r_enc2  <= n_enc;
            r_last2 <= r_last1;
        end
    end

    // Stage 3: base size, 909 plus length plus overhead.
    logic [ROW_W:0] n_base;
    logic [ROW_W:0] r_base3;
    logic           r_last3;

    assign n_base = ROW_BASE + {2'b0, r_len2} + {2'b0, r_enc2};

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_base3 <= n_base;
            r_last3 <= r_last2;
        end
    end

    // Stage 4: add a tenth of the base and saturate.
    logic [22:0]      tenth;
    logic [ROW_W+1:0] row_full;
    logic [ROW_W-1:0] n_row;
    logic [ROW_W-1:0] r_row4;
    logic             r_last4;

    assign tenth    = div5(r_base3[ROW_W:1]);
    assign row_full = {1'b0, r_base3} + (ROW_W + 2)'(tenth);
    assign n_row    = (row_full > (ROW_W + 2)'(ROW_MAX)) ? ROW_MAX : row_full[ROW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_row4  <= n_row;
            r_last4 <= r_last3;
        end
    end

    // Batch state: running byte sum and message count.
    logic [BYTES_W-1:0] r_acc_bytes;
    logic [CNT_W-1:0]   r_msg_count;

    // Close decision for the open batch before this word joins it.
    logic [BYTES_W:0]   sum_chk;
    logic [BYTES_W:0]   max_lim;
    logic [BYTES_W-1:0] tgt_lim;
    logic               over_max;
    logic               size_close;
    logic               close;
    logic [BYTES_W-1:0] keep_acc;
    logic [CNT_W-1:0]   keep_cnt;
    logic [BYTES_W:0]   join_sum;
    logic [BYTES_W-1:0] join_acc;
    logic [CNT_W-1:0]   join_cnt;
    logic               step;

    assign sum_chk  = {1'b0, r_acc_bytes} + (BYTES_W + 1)'(r_row4);
    assign max_lim  = {1'b0, r_max_mb, MIB_SHIFT'(0)};
    assign tgt_lim  = {r_target_mb, MIB_SHIFT'(0)};
    assign over_max = sum_chk > max_lim;

    assign size_close = over_max || (r_msg_count >= r_max_msgs)
                     || ((r_acc_bytes >= tgt_lim) && (r_msg_count >= r_min_msgs));

    assign close = (r_msg_count != '0)
                && ((&r_msg_count)
                    || (r_size_mode ? size_close : (r_msg_count >= r_chunk_msgs)));

    // The word joins the batch left after a possible close.
    assign keep_acc = close ? '0 : r_acc_bytes;
    assign keep_cnt = close ? '0 : r_msg_count;
    assign join_sum = {1'b0, keep_acc} + (BYTES_W + 1)'(r_row4);
    assign join_acc = join_sum[BYTES_W] ? '1 : join_sum[BYTES_W-1:0];
    assign join_cnt = (&keep_cnt) ? keep_cnt : keep_cnt + CNT_W'(1);

    assign step = r_v4 && rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_bytes <= '0;
            r_msg_count <= '0;
        end else if (step) begin
            r_acc_bytes <= r_last4 ? '0 : join_acc;
            r_msg_count <= r_last4 ? '0 : join_cnt;
        end
    end

    // Result register.
    logic               r_prev_closed;
    logic [CNT_W-1:0]   r_prev_count;
    logic [BYTES_W-1:0] r_prev_bytes;
    logic               r_final_closed;
    logic [CNT_W-1:0]   r_final_count;
    logic [BYTES_W-1:0] r_final_bytes;
    logic [ROW_W-1:0]   r_row_bytes;

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            r_prev_closed  <= close;
            r_prev_count   <= close ? r_msg_count : '0;
            r_prev_bytes   <= close ? r_acc_bytes : '0;
            r_final_closed <= r_last4;
            r_final_count  <= r_last4 ? join_cnt : '0;
            r_final_bytes  <= r_last4 ? join_acc : '0;
            r_row_bytes    <= r_row4;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_prev_closed  = r_prev_closed;
    assign o_prev_count   = r_prev_count;
    assign o_prev_bytes   = r_prev_bytes;
    assign o_final_closed = r_final_closed;
    assign o_final_count  = r_final_count;
    assign o_final_bytes  = r_final_bytes;
    assign o_row_bytes    = r_row_bytes;

endmodule

// ----- rtl/sabs_checker.sv -----
// Port-level checker for the size-aware batch splitter and its bind.
// Depends on sabs_pkg and size_aware_batch_splitter_unit.
`timescale 1ns / 1ps

module sabs_checker
    import sabs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_prev_closed,
    input logic [CNT_W-1:0]   o_prev_count,
    input logic [BYTES_W-1:0] o_prev_bytes,
    input logic               o_final_closed,
    input logic [CNT_W-1:0]   o_final_count,
    input logic [BYTES_W-1:0] o_final_bytes,
    input logic [ROW_W-1:0]   o_row_bytes
);

    // A batch reported as not closed carries no count and no bytes.
    a_prev_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_prev_closed) |-> (o_prev_count == '0 && o_prev_bytes == '0))
        else $error("prev batch fields set without a close");

    a_final_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_final_closed) |-> (o_final_count == '0 && o_final_bytes == '0))
        else $error("final batch fields set without a close");

    // A closed batch always holds at least one message.
    a_prev_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_prev_closed) |-> (o_prev_count != '0))
        else $error("empty batch closed before a word");

    a_final_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_final_closed) |-> (o_final_count != '0 && o_final_bytes >= BYTES_W'(o_row_bytes)))
        else $error("final batch smaller than its last word");

    // A stalled result word stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_row_bytes) && $stable(o_final_bytes)))
        else $error("stalled result word changed");

endmodule

bind size_aware_batch_splitter_unit sabs_checker u_sabs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_prev_closed  (o_prev_closed),
    .o_prev_count   (o_prev_count),
    .o_prev_bytes   (o_prev_bytes),
    .o_final_closed (o_final_closed),
    .o_final_count  (o_final_count),
    .o_final_bytes  (o_final_bytes),
    .o_row_bytes    (o_row_bytes)
);

// ----- verif/tb.sv -----
// Self-checking testbench for size_aware_batch_splitter_unit: directed and random
// message groups, configuration changes, random idling and back-pressure.
// Depends on sabs_pkg and the splitter RTL.
`timescale 1ns / 1ps

module tb;
    import sabs_pkg::*;

    localparam int               IDLE_LIMIT   = 2000;
    localparam int               RANDOM_WORDS = 820;
    localparam int               DRAIN_CYCLES = 20;
    localparam logic [LEN_W-1:0]   LEN_ALL_ONES = '1;
    localparam logic [CNT_W-1:0]   COUNT_FULL   = '1;
    localparam logic [BYTES_W-1:0] BYTES_FULL   = '1;
    localparam logic [ROW_W-1:0]   ROW_FULL     = '1;

    // One result word of the splitter.
    typedef struct packed {
        logic               prev_closed;
        logic [CNT_W-1:0]   prev_count;
        logic [BYTES_W-1:0] prev_bytes;
        logic               final_closed;
        logic [CNT_W-1:0]   final_count;
        logic [BYTES_W-1:0] final_bytes;
        logic [ROW_W-1:0]   row_bytes;
    } split_outcome_t;

    // Tracks the batch state, predicts one result word per accepted message and
    // checks the result words in order.
    class batch_scoreboard;
        logic               size_mode;
        logic               encrypt_on;
        logic [MB_W-1:0]    target_mb;
        logic [MB_W-1:0]    max_mb;
        logic [CNT_W-1:0]   min_msgs;
        logic [CNT_W-1:0]   max_msgs;
        logic [CNT_W-1:0]   chunk_msgs;
        logic [BYTES_W-1:0] acc_bytes;
        logic [CNT_W-1:0]   msg_count;
        split_outcome_t     pending_outcomes[$];
        int                 errors;

        function new();
            size_mode  = 1'b1;
            encrypt_on = 1'b0;
            target_mb  = MB_W'(4);
            max_mb     = MB_W'(8);
            min_msgs   = CNT_W'(100);
            max_msgs   = CNT_W'(10000);
            chunk_msgs = CNT_W'(1000);
            acc_bytes  = '0;
            msg_count  = '0;
            errors     = 0;
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        function void write_reg(t_cfg_idx idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_SIZE_MODE:  size_mode  = data[0];
                CFG_ENCRYPT_ON: encrypt_on = data[0];
                CFG_TARGET_MB:  target_mb  = data[MB_W-1:0];
                CFG_MAX_MB:     max_mb     = data[MB_W-1:0];
                CFG_MIN_MSGS:   min_msgs   = data[CNT_W-1:0];
                CFG_MAX_MSGS:   max_msgs   = data[CNT_W-1:0];
                CFG_CHUNK_MSGS: chunk_msgs = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Stored row size: 609 + len + 300, the encryption overhead when enabled,
        // then a tenth on top, saturated to the row width.
        function logic [ROW_W-1:0] estimate_row(logic [LEN_W-1:0] len);
            logic [33:0] base;
            base = 34'(len) + 34'd609 + 34'd300;
            if (encrypt_on) begin
                base = base + (34'(len) * 34'd7) / 34'd20 + 34'd200;
            end
            base = base + base / 34'd10;
            if (base > 34'(ROW_FULL)) begin
                return ROW_FULL;
            end
            return base[ROW_W-1:0];
        endfunction

        // Decide whether the open batch closes first, add the message, and close
        // the batch again when the message ends the group.
        function void note_message(logic [LEN_W-1:0] len, logic last);
            split_outcome_t  want;
            logic [ROW_W-1:0] row;
            logic [33:0]     sum;
            logic            close_prev;
            want = '0;
            row = estimate_row(len);
            close_prev = 1'b0;
            if (msg_count != '0) begin
                if (msg_count == COUNT_FULL) begin
                    close_prev = 1'b1;
                end else if (size_mode) begin
                    if (34'(acc_bytes) + 34'(row) > (34'(max_mb) << MIB_SHIFT)) begin
                        close_prev = 1'b1;
                    end else if (msg_count >= max_msgs) begin
                        close_prev = 1'b1;
                    end else if (34'(acc_bytes) >= (34'(target_mb) << MIB_SHIFT) &&
                                 msg_count >= min_msgs) begin
                        close_prev = 1'b1;
                    end
                end else if (msg_count >= chunk_msgs) begin
                    close_prev = 1'b1;
                end
            end
            if (close_prev) begin
                want.prev_closed = 1'b1;
                want.prev_count  = msg_count;
                want.prev_bytes  = acc_bytes;
                acc_bytes = '0;
                msg_count = '0;
            end
            // The byte sum saturates; the count stops at its maximum.
            sum = 34'(acc_bytes) + 34'(row);
            acc_bytes = (sum > 34'(BYTES_FULL)) ? BYTES_FULL : sum[BYTES_W-1:0];
            if (msg_count != COUNT_FULL) begin
                msg_count = msg_count + 1'b1;
            end
            if (last) begin
                want.final_closed = 1'b1;
                want.final_count  = msg_count;
                want.final_bytes  = acc_bytes;
                acc_bytes = '0;
                msg_count = '0;
            end
            want.row_bytes = row;
            pending_outcomes.insert(pending_outcomes.size(), want);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_outcome(split_outcome_t got);
            split_outcome_t want;
            if (pending_outcomes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual row_bytes %0d",
                         $time, got.row_bytes);
                return;
            end
            want = pending_outcomes.pop_front();
            compare("prev_closed", 32'(want.prev_closed), 32'(got.prev_closed));
            compare("prev_count", 32'(want.prev_count), 32'(got.prev_count));
            compare("prev_bytes", 32'(want.prev_bytes), 32'(got.prev_bytes));
            compare("final_closed", 32'(want.final_closed), 32'(got.final_closed));
            compare("final_count", 32'(want.final_count), 32'(got.final_count));
            compare("final_bytes", 32'(want.final_bytes), 32'(got.final_bytes));
            compare("row_bytes", 32'(want.row_bytes), 32'(got.row_bytes));
        endfunction
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    logic [LEN_W-1:0]   i_payload_len  = '0;
    logic               i_last_item    = 1'b0;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index    = '0;
    logic [DATA_W-1:0]  i_cfg_data     = '0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    logic               o_prev_closed;
    logic [CNT_W-1:0]   o_prev_count;
    logic [BYTES_W-1:0] o_prev_bytes;
    logic               o_final_closed;
    logic [CNT_W-1:0]   o_final_count;
    logic [BYTES_W-1:0] o_final_bytes;
    logic [ROW_W-1:0]   o_row_bytes;

    batch_scoreboard splitter_sb;

    // Idling limits for the two sides, a one-off long stall request for the
    // result side, and the configuration staged for the next write burst.
    int          tx_gap_max      = 0;
    int          rx_stall_max    = 0;
    int          rx_hold_cycles  = 0;
    int          words_sent      = 0;
    int unsigned cfg_next [7];
    bit [6:0]    cfg_mask        = '0;

    size_aware_batch_splitter_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_payload_len  (i_payload_len),
        .i_last_item    (i_last_item),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_prev_closed  (o_prev_closed),
        .o_prev_count   (o_prev_count),
        .o_prev_bytes   (o_prev_bytes),
        .o_final_closed (o_final_closed),
        .o_final_count  (o_final_count),
        .o_final_bytes  (o_final_bytes),
        .o_row_bytes    (o_row_bytes)
    );

    always #6 i_clk = ~i_clk;

    // Observe every handshake at the clock edge and feed the scoreboard.
    always @(posedge i_clk) begin : monitor
        split_outcome_t seen;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                splitter_sb.note_message(i_payload_len, i_last_item);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                splitter_sb.write_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
            end
            if (o_valid && !i_stall) begin
                seen.prev_closed  = o_prev_closed;
                seen.prev_count   = o_prev_count;
                seen.prev_bytes   = o_prev_bytes;
                seen.final_closed = o_final_closed;
                seen.final_count  = o_final_count;
                seen.final_bytes  = o_final_bytes;
                seen.row_bytes    = o_row_bytes;
                splitter_sb.check_outcome(seen);
            end
        end
    end

    // Result side: stall a random number of cycles before each word, or hold off
    // for a long stretch when asked to.
    initial begin : result_sink
        int n;
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                n = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Ends the run when no word moves on any channel for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one message after a random gap and hold it until it is taken.
    task automatic send_word(input logic [LEN_W-1:0] len, input logic last);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_payload_len <= len;
        i_last_item   <= last;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
    endtask

    // Stop offering and wait until every expected result word has arrived.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (splitter_sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx r, input int unsigned value);
        cfg_next[r] = value;
        cfg_mask[r] = 1'b1;
    endtask

    // Write the staged registers back to back, in index order.
    task automatic apply_config();
        t_cfg_idx r;
        r = r.first();
        forever begin
            if (cfg_mask[r]) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= r;
                i_cfg_data  <= DATA_W'(cfg_next[r]);
                do @(posedge i_clk); while (!o_cfg_ready);
            end
            if (r == r.last()) break;
            r = r.next();
        end
        i_cfg_valid <= 1'b0;
        cfg_mask = '0;
    endtask

    // Mostly small and medium payloads, with the extremes and full-range values.
    function automatic logic [LEN_W-1:0] draw_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LEN_ALL_ONES;
            2, 3: return LEN_W'($urandom());
            4, 5: return LEN_W'($urandom_range(0, 4095));
            default: return LEN_W'($urandom_range(0, 300000));
        endcase
    endfunction

    // Limits that make batches close often, plus the extremes and full ranges.
    function automatic int unsigned draw_reg_value(input t_cfg_idx r);
        int unsigned pick;
        pick = $urandom_range(0, 5);
        case (r)
            CFG_SIZE_MODE:  return ($urandom_range(0, 3) != 0);
            CFG_ENCRYPT_ON: return $urandom_range(0, 1);
            CFG_TARGET_MB:
                case (pick)
                    0: return 0;
                    1: return 1024;
                    2: return $urandom_range(0, 1024);
                    default: return $urandom_range(1, 4);
                endcase
            CFG_MAX_MB:
                case (pick)
                    0: return 1024;
                    1: return 1;
                    2: return $urandom_range(1, 1024);
                    default: return $urandom_range(1, 16);
                endcase
            CFG_MIN_MSGS:
                case (pick)
                    0: return 0;
                    1: return 65535;
                    2: return $urandom_range(0, 65535);
                    default: return $urandom_range(0, 12);
                endcase
            CFG_MAX_MSGS:
                case (pick)
                    0: return 65535;
                    1: return 1;
                    2: return $urandom_range(1, 65535);
                    default: return $urandom_range(1, 30);
                endcase
            default:
                case (pick)
                    0: return 65535;
                    1: return 1;
                    2: return $urandom_range(1, 65535);
                    default: return $urandom_range(1, 20);
                endcase
        endcase
    endfunction

    task automatic randomize_config();
        t_cfg_idx r;
        r = r.first();
        forever begin
            if ($urandom_range(0, 2) == 0) begin
                set_reg(r, draw_reg_value(r));
            end
            if (r == r.last()) break;
            r = r.next();
        end
        apply_config();
    endtask

    // A group of messages; most groups end with the last flag, a few stay open,
    // and a stray last flag now and then splits a group early.
    task automatic send_group(input int n, input bit closed);
        int k;
        for (k = 0; k < n; k++) begin
            send_word(draw_len(), (closed && k == n - 1) || ($urandom_range(0, 49) == 0));
        end
    endtask

    initial begin : stimulus
        int k;
        int random_end;
        splitter_sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: a row above the byte maximum still opens a batch
        // of its own, and a one-message group.
        send_word('0, 1'b0);
        send_word(LEN_ALL_ONES, 1'b0);
        send_word(LEN_ALL_ONES, 1'b0);
        send_word('0, 1'b1);
        send_word(LEN_W'(1), 1'b1);

        // Encryption overhead on the largest payload.
        wait_drained();
        set_reg(CFG_ENCRYPT_ON, 1);
        apply_config();
        send_word(LEN_ALL_ONES, 1'b0);
        send_word(LEN_W'(12345), 1'b0);
        send_word('0, 1'b1);

        // Count mode, group left open across a switch back to size mode.
        wait_drained();
        set_reg(CFG_SIZE_MODE, 0);
        set_reg(CFG_CHUNK_MSGS, 3);
        apply_config();
        for (k = 0; k < 5; k++) send_word(LEN_W'(k * 7), 1'b0);
        wait_drained();
        set_reg(CFG_SIZE_MODE, 1);
        set_reg(CFG_TARGET_MB, 0);
        set_reg(CFG_MAX_MB, 1);
        set_reg(CFG_MIN_MSGS, 2);
        set_reg(CFG_MAX_MSGS, 4);
        apply_config();
        for (k = 0; k < 4; k++) send_word(LEN_W'(200000), k == 3);

        // Zero message limits in both modes.
        wait_drained();
        set_reg(CFG_MAX_MSGS, 0);
        apply_config();
        for (k = 0; k < 3; k++) send_word(LEN_W'(k + 100), k == 2);
        wait_drained();
        set_reg(CFG_SIZE_MODE, 0);
        set_reg(CFG_CHUNK_MSGS, 0);
        apply_config();
        for (k = 0; k < 3; k++) send_word(LEN_W'(k), k == 2);

        // Byte sum saturation: large encrypted rows in one long chunk.
        wait_drained();
        set_reg(CFG_CHUNK_MSGS, 200);
        apply_config();
        tx_gap_max = 18;
        rx_stall_max = 18;
        for (k = 0; k < 100; k++) send_word(LEN_ALL_ONES, k == 99);

        // Back-pressure: the result side holds off while messages keep coming,
        // then the sender pauses mid-group until everything is out.
        wait_drained();
        set_reg(CFG_SIZE_MODE, 1);
        set_reg(CFG_MAX_MB, 2);
        set_reg(CFG_TARGET_MB, 1);
        set_reg(CFG_MIN_MSGS, 3);
        set_reg(CFG_MAX_MSGS, 25);
        apply_config();
        tx_gap_max = 0;
        rx_hold_cycles = 300;
        send_group(80, 1'b1);
        rx_stall_max = 0;
        send_group(10, 1'b0);
        wait_drained();
        send_group(10, 1'b1);

        // Random configurations and groups, idling switched per segment.
        random_end = words_sent + RANDOM_WORDS;
        while (words_sent < random_end) begin
            wait_drained();
            randomize_config();
            tx_gap_max = $urandom_range(0, 1) ? 18 : 0;
            rx_stall_max = $urandom_range(0, 1) ? 18 : 0;
            repeat ($urandom_range(1, 3)) begin
                send_group($urandom_range(1, 60), $urandom_range(0, 4) != 0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (splitter_sb.errors == 0 && splitter_sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sabs_pkg.sv
rtl/size_aware_batch_splitter_unit.sv
rtl/sabs_checker.sv
verif/tb.sv
